/* rtl/xrr_pkg.sv */
`default_nettype none
package xrr_pkg;

	localparam int unsigned WordW  = 32;
	localparam int unsigned CountW = $clog2(WordW);

	// xorshift32 shift amounts
	localparam int unsigned ShiftA = 13;
	localparam int unsigned ShiftB = 17;
	localparam int unsigned ShiftC = 5;

	localparam logic [WordW-1:0] StateOne = WordW'(1);

	typedef logic [WordW-1:0] word_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_HOLD = 3'b100
	} seq_state_t;

	// one xorshift32 step
	function automatic word_t xs_advance(input word_t s);
		word_t t;
		t = s;
		t = t ^ (t << ShiftA);
		t = t ^ (t >> ShiftB);
		t = t ^ (t << ShiftC);
		return t;
	endfunction

endpackage
`default_nettype wire

/* rtl/xrr_divider.sv */
`default_nettype none
// Radix-2 restoring remainder unit, one dividend bit per cycle.
module xrr_divider (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	input  wire  xrr_pkg::word_t dividend,
	input  wire  xrr_pkg::word_t divisor,
	output xrr_pkg::word_t      remainder,
	output xrr_pkg::div_status_t status
);
	import xrr_pkg::*;

	word_t             rem_q;
	word_t             dvd_q;
	word_t             dvs_q;
	logic [CountW-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [WordW:0] trial;
	logic [WordW:0] diff;

	// shift in next dividend bit, try the subtract
	assign trial = {rem_q, dvd_q[WordW-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CountW'(1);
				if (cnt_q == CountW'(WordW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (!diff[WordW]) begin
				rem_q <= diff[WordW-1:0];
			end else begin
				rem_q <= trial[WordW-1:0];
			end
		end
	end

	assign remainder   = rem_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule
`default_nettype wire

/* rtl/xorshift_ranged_random_core.sv */
// Ranged xorshift32 random number core.
//
// Input channel (in_valid/in_ready) takes one request beat: signed bounds
// low_bound (inclusive) and high_bound (exclusive). Output channel
// (out_valid/out_ready) returns one beat per request: random_value in
// [low_bound, high_bound), or low_bound when the range is empty.
// seed_we with seed_value reloads the generator in the same edge; a zero
// seed loads 1. Write the seed only while no request is in flight.
//
// For a non-empty range the accept edge steps the generator and loads the
// bit-serial divider, the divider runs one remainder iteration per dividend
// bit, then the offset is added into the result register and the result is
// loaded into the output register, which raises out_valid.
// An empty range skips the divider, goes straight to the output register
// load and leaves the generator unchanged.
// One request is worked at a time; in_ready is low from accept until the
// result moves into the output register, so the core never takes a new request
// while the previous one is still being worked.
// A stalled receiver holds the result in the output register; the core
// keeps one more finished result waiting internally before it stalls.
// Reset leaves the generator at 1 and both channels empty.
`default_nettype none
module xorshift_ranged_random_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 seed_we,
	input  wire  xrr_pkg::word_t seed_value,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire  xrr_pkg::word_t low_bound,
	input  wire  xrr_pkg::word_t high_bound,
	output logic                out_valid,
	input  wire                 out_ready,
	output xrr_pkg::word_t      random_value
);
	import xrr_pkg::*;

	seq_state_t  state_q;
	word_t       gen_q;
	word_t       low_q;
	word_t       res_q;
	word_t       out_q;
	logic        out_valid_q;

	logic        accept;
	logic        empty_range;
	word_t       gen_next;
	word_t       span;
	logic        div_start;
	word_t       div_rem;
	div_status_t div_st;
	logic        out_load;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign empty_range = ($signed(low_bound) >= $signed(high_bound));
	assign gen_next    = xs_advance(gen_q);
	assign span        = high_bound - low_bound;
	assign div_start   = accept && !empty_range;
	assign out_load    = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	xrr_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (gen_next),
		.divisor   (span),
		.remainder (div_rem),
		.status    (div_st)
	);

	// sequencer and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gen_q   <= StateOne;
		end else begin
			if (seed_we) begin
				gen_q <= (seed_value == '0) ? StateOne : seed_value;
			end else if (div_start) begin
				gen_q <= gen_next;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= empty_range ? ST_HOLD : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result staging
	always_ff @(posedge clk) begin
		if (accept) begin
			low_q <= low_bound;
			res_q <= low_bound;
		end else if (state_q == ST_DIV && div_st.done) begin
			res_q <= low_q + div_rem;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign random_value = out_q;

endmodule
`default_nettype wire

/* rtl/xrr_checker.sv */
`default_nettype none
module xrr_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_ready,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire  xrr_pkg::word_t random_value
);
	import xrr_pkg::*;

	// stalled result beat holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(random_value))
		else $error("output beat changed while stalled");

	// one request at a time: ready drops after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("core ready right after accepting a beat");

	// a new result only appears out of a busy period
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in flight");

	// result load returns the core to ready
	a_ready_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("core not ready after loading a result");

endmodule

bind xorshift_ranged_random_core xrr_checker u_xrr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.random_value (random_value)
);
`default_nettype wire
